// ===== design/rfor_pkg.sv =====
// Shared types and constants for the rectangle fill/outline raster block.
// No dependencies; used by the interfaces and the top level.
package rfor_pkg;

    // Beat field widths
    localparam int COORD_W = 19;
    localparam int CHAR_W  = 8;
    localparam int PIX_W   = 9;
    localparam int DIM_W   = 10;

    // APB register file
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    typedef enum logic [1:0] {
        REG_CANVAS_WIDTH  = 2'd0,
        REG_CANVAS_HEIGHT = 2'd1,
        REG_BACKGROUND    = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_idx;

    localparam logic [DIM_W-1:0]  RST_CANVAS_WIDTH  = 10'd1;
    localparam logic [DIM_W-1:0]  RST_CANVAS_HEIGHT = 10'd1;
    localparam logic [CHAR_W-1:0] RST_BACKGROUND    = 8'd32;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_FILL    = 2'd1,
        OP_OUTLINE = 2'd2,
        OP_READ    = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_DONE     = 1'b0,
        ST_REJECTED = 1'b1
    } t_status;

endpackage

// ===== design/rfor_if.sv =====
// Valid/ready channel interfaces for command and response beats.
// Depends on rfor_pkg for field widths.
interface rfor_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            opcode;
    logic signed [rfor_pkg::COORD_W-1:0]   rect_left;
    logic signed [rfor_pkg::COORD_W-1:0]   rect_top;
    logic signed [rfor_pkg::COORD_W-1:0]   rect_w;
    logic signed [rfor_pkg::COORD_W-1:0]   rect_h;
    logic [rfor_pkg::CHAR_W-1:0]           fill_char;
    logic [rfor_pkg::PIX_W-1:0]            pixel_col;
    logic [rfor_pkg::PIX_W-1:0]            pixel_row;

    modport source (output valid, opcode, rect_left, rect_top, rect_w, rect_h,
                    fill_char, pixel_col, pixel_row, input ready);
    modport sink   (input valid, opcode, rect_left, rect_top, rect_w, rect_h,
                    fill_char, pixel_col, pixel_row, output ready);
endinterface

interface rfor_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [rfor_pkg::CHAR_W-1:0] pixel_char;

    modport source (output valid, status, pixel_char, input ready);
    modport sink   (input valid, status, pixel_char, output ready);
endinterface

// ===== design/rect_fill_outline_raster_top.sv =====
// Character framebuffer with clear, filled/outlined rectangle paint and pixel read.
// Depends on rfor_pkg and the channel interfaces in rfor_if.sv.
//
// Usage:
//   i_cmd carries one command beat (clear, fill, outline or read); o_rsp returns
//   exactly one response beat per command (status, pixel_char). The APB port
//   holds canvas_width (0x0), canvas_height (0x4) and background_char (0x8);
//   write it only while no command is in flight.
//   Draw and clear walk the canvas in use one pixel per cycle through a single
//   compare/paint datapath and the one port of the canvas memory; the canvas
//   in use is min(canvas_width, MAX_WIDTH) by min(canvas_height, MAX_HEIGHT).
//   Clear starts its sweep straight from accept; fill and outline first pass a
//   setup state that registers the edge bounds; read passes a state for the
//   registered memory read; a rejected item goes straight to the done state.
//   i_cmd.ready is high only while the sequencer is idle; one item at a time.
//   Reset returns the registers to width 1, height 1, background 0x20 and
//   empties the response register; canvas contents are undefined until drawn.
//   A stalled response sits in the output register; the next command is still
//   taken and runs, and holds its own response until the register frees up.
module rect_fill_outline_raster_top #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rfor_cmd_if.sink                    i_cmd,
    rfor_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfor_pkg::APB_AW-1:0] paddr,
    input  logic [rfor_pkg::APB_DW-1:0] pwdata,
    output logic [rfor_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    // Index and count widths
    localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CWN = $clog2(MAX_WIDTH + 1);
    localparam int RWN = $clog2(MAX_HEIGHT + 1);
    localparam int MEM_DEPTH = 2 ** (RW + CW);
    // Signed coordinate width: holds left+w-one and row/col scaled by 2^FRAC_BITS
    localparam int PW  = ((CW > RW) ? CW : RW) + FRAC_BITS + 2;
    localparam int EW  = (PW > rfor_pkg::COORD_W + 3) ? PW : rfor_pkg::COORD_W + 3;
    localparam int SX  = EW - rfor_pkg::COORD_W;
    localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SWEEP,
        S_READ,
        S_DONE
    } t_state;

    // Configuration registers
    logic [rfor_pkg::DIM_W-1:0]  r_canvas_width;
    logic [rfor_pkg::DIM_W-1:0]  r_canvas_height;
    logic [rfor_pkg::CHAR_W-1:0] r_background;
    logic                        w_cfg_wr;
    rfor_pkg::t_reg_idx          w_cfg_idx;

    // Sequencer and datapath
    t_state                      r_state;
    rfor_pkg::t_opcode           r_op;
    logic [CW-1:0]               r_col;
    logic [RW-1:0]               r_row;
    logic [rfor_pkg::CHAR_W-1:0] r_char;
    logic signed [EW-1:0]        r_left, r_top, r_w, r_h;
    logic signed [EW-1:0]        r_right, r_bottom, r_lp1, r_tp1, r_rm1, r_bm1;
    logic                        r_status;
    logic                        r_out_valid;
    logic                        r_out_status;
    logic [rfor_pkg::CHAR_W-1:0] r_out_pix;
    logic [rfor_pkg::CHAR_W-1:0] r_rd_data;

    logic [rfor_pkg::CHAR_W-1:0] mem [MEM_DEPTH];

    logic [CWN-1:0]              w_wc;
    logic [RWN-1:0]              w_hc;
    logic                        w_empty;
    logic                        w_in_acc;
    logic                        w_out_free;
    rfor_pkg::t_opcode           w_in_op;
    logic                        w_size_bad;
    logic                        w_rd_oob;
    logic signed [EW-1:0]        w_xf, w_yf;
    logic                        w_rin, w_redge, w_cin, w_cedge;
    logic                        w_paint;
    logic                        w_last_col, w_last_row;
    logic [RW+CW-1:0]            w_addr;

    // APB register file
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = rfor_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= rfor_pkg::RST_CANVAS_WIDTH;
            r_canvas_height <= rfor_pkg::RST_CANVAS_HEIGHT;
            r_background    <= rfor_pkg::RST_BACKGROUND;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                rfor_pkg::REG_CANVAS_WIDTH:  r_canvas_width  <= pwdata[rfor_pkg::DIM_W-1:0];
                rfor_pkg::REG_CANVAS_HEIGHT: r_canvas_height <= pwdata[rfor_pkg::DIM_W-1:0];
                rfor_pkg::REG_BACKGROUND:    r_background    <= pwdata[rfor_pkg::CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            rfor_pkg::REG_CANVAS_WIDTH:  prdata = rfor_pkg::APB_DW'(r_canvas_width);
            rfor_pkg::REG_CANVAS_HEIGHT: prdata = rfor_pkg::APB_DW'(r_canvas_height);
            rfor_pkg::REG_BACKGROUND:    prdata = rfor_pkg::APB_DW'(r_background);
            default:                     prdata = '0;
        endcase
    end

    // Canvas size in use, clamped to the store
    assign w_wc = (32'(r_canvas_width) > MAX_WIDTH) ? CWN'(MAX_WIDTH) : CWN'(r_canvas_width);
    assign w_hc = (32'(r_canvas_height) > MAX_HEIGHT) ? RWN'(MAX_HEIGHT)
                                                      : RWN'(r_canvas_height);
    assign w_empty = (w_wc == '0) || (w_hc == '0);

    // Command decode at accept
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;
    assign w_in_op     = rfor_pkg::t_opcode'(i_cmd.opcode);
    assign w_size_bad  = i_cmd.rect_w[rfor_pkg::COORD_W-1] || (i_cmd.rect_w == '0) ||
                         i_cmd.rect_h[rfor_pkg::COORD_W-1] || (i_cmd.rect_h == '0);
    assign w_rd_oob    = (32'(i_cmd.pixel_col) >= 32'(w_wc)) ||
                         (32'(i_cmd.pixel_row) >= 32'(w_hc));

    // Per-pixel paint decision (shared compare unit)
    assign w_xf    = signed'(EW'(r_col)) << FRAC_BITS;
    assign w_yf    = signed'(EW'(r_row)) << FRAC_BITS;
    assign w_rin   = (r_top <= w_yf) && (w_yf <= r_bottom);
    assign w_redge = (w_yf < r_tp1) || (w_yf > r_bm1);
    assign w_cin   = (r_left <= w_xf) && (w_xf <= r_right);
    assign w_cedge = (w_xf < r_lp1) || (w_xf > r_rm1);
    always_comb begin
        case (r_op)
            rfor_pkg::OP_CLEAR:   w_paint = 1'b1;
            rfor_pkg::OP_FILL:    w_paint = w_rin && w_cin;
            rfor_pkg::OP_OUTLINE: w_paint = w_rin && w_cin && (w_redge || w_cedge);
            default:              w_paint = 1'b0;
        endcase
    end

    assign w_last_col = (32'(r_col) + 32'd1 == 32'(w_wc));
    assign w_last_row = (32'(r_row) + 32'd1 == 32'(w_hc));
    assign w_addr     = {r_row, r_col};
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Canvas store: single port, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_SWEEP && w_paint) begin
            mem[w_addr] <= r_char;
        end
        r_rd_data <= mem[w_addr];
    end

    // Sequencer, operand registers and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // load on finish, else drain on handshake
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op     <= w_in_op;
                        r_left   <= {{SX{i_cmd.rect_left[rfor_pkg::COORD_W-1]}},
                                     i_cmd.rect_left};
                        r_top    <= {{SX{i_cmd.rect_top[rfor_pkg::COORD_W-1]}},
                                     i_cmd.rect_top};
                        r_w      <= {{SX{i_cmd.rect_w[rfor_pkg::COORD_W-1]}}, i_cmd.rect_w};
                        r_h      <= {{SX{i_cmd.rect_h[rfor_pkg::COORD_W-1]}}, i_cmd.rect_h};
                        unique case (w_in_op)
                            rfor_pkg::OP_CLEAR: begin
                                r_col    <= '0;
                                r_row    <= '0;
                                r_status <= rfor_pkg::ST_DONE;
                                r_char   <= r_background;
                                r_state  <= w_empty ? S_DONE : S_SWEEP;
                            end
                            rfor_pkg::OP_READ: begin
                                r_col <= CW'(32'(i_cmd.pixel_col));
                                r_row <= RW'(32'(i_cmd.pixel_row));
                                if (w_rd_oob) begin
                                    r_status <= rfor_pkg::ST_REJECTED;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= rfor_pkg::ST_DONE;
                                    r_state  <= S_READ;
                                end
                            end
                            default: begin
                                r_col  <= '0;
                                r_row  <= '0;
                                r_char <= i_cmd.fill_char;
                                if (w_size_bad) begin
                                    r_status <= rfor_pkg::ST_REJECTED;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= rfor_pkg::ST_DONE;
                                    r_state  <= S_SETUP;
                                end
                            end
                        endcase
                    end
                end
                S_SETUP: begin
                    // edge bounds for the sweep compares
                    r_right  <= r_left + r_w;
                    r_bottom <= r_top + r_h;
                    r_lp1    <= r_left + ONE;
                    r_tp1    <= r_top + ONE;
                    r_rm1    <= r_left + r_w - ONE;
                    r_bm1    <= r_top + r_h - ONE;
                    r_state  <= w_empty ? S_DONE : S_SWEEP;
                end
                S_SWEEP: begin
                    if (w_last_col) begin
                        r_col <= '0;
                        if (w_last_row) begin
                            r_state <= S_DONE;
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_status <= r_status;
                        r_out_pix    <= (r_op == rfor_pkg::OP_READ && !r_status) ?
                                        r_rd_data : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.pixel_char = r_out_pix;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_cmd.ready)
        else $error("command taken while sequencer busy");

    a_sweep_in_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (32'(r_col) < 32'(w_wc)) && (32'(r_row) < 32'(w_hc)))
        else $error("sweep outside canvas in use");

    a_reject_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |-> (o_rsp.pixel_char == '0))
        else $error("rejected response carries a character");

    a_done_loads_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_rsp.valid && r_state == S_IDLE))
        else $error("finished item did not reach the response register");

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for rect_fill_outline_raster_top: paints and reads a shadow
// canvas alongside the block and checks every response beat field by field.
// Depends on rfor_pkg, the rfor_if channel interfaces and the block's top level.
`timescale 1ns / 100ps

module tb;

    localparam int CANVAS_MAX_W = 512;
    localparam int CANVAS_MAX_H = 512;
    localparam int ONE          = 256;          // 1.0 in Q10.8
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    localparam logic signed [rfor_pkg::COORD_W-1:0] Q_MIN =
        {1'b1, {(rfor_pkg::COORD_W-1){1'b0}}};
    localparam logic signed [rfor_pkg::COORD_W-1:0] Q_MAX =
        {1'b0, {(rfor_pkg::COORD_W-1){1'b1}}};

    localparam logic [rfor_pkg::CHAR_W-1:0] CH_UPPER_R = "R";
    localparam logic [rfor_pkg::CHAR_W-1:0] CH_LOWER_R = "r";
    localparam logic [rfor_pkg::CHAR_W-1:0] CH_HASH    = "#";
    localparam logic [rfor_pkg::CHAR_W-1:0] CH_DOT     = ".";
    localparam logic [rfor_pkg::CHAR_W-1:0] CH_STAR    = "*";

    typedef struct {
        rfor_pkg::t_opcode                   op;
        logic signed [rfor_pkg::COORD_W-1:0] left;
        logic signed [rfor_pkg::COORD_W-1:0] top;
        logic signed [rfor_pkg::COORD_W-1:0] w;
        logic signed [rfor_pkg::COORD_W-1:0] h;
        logic [rfor_pkg::CHAR_W-1:0]         ch;
        logic [rfor_pkg::PIX_W-1:0]          col;
        logic [rfor_pkg::PIX_W-1:0]          row;
    } t_paint_cmd;

    typedef struct {
        rfor_pkg::t_status           status;
        logic [rfor_pkg::CHAR_W-1:0] pix;
    } t_reply;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rfor_pkg::APB_AW-1:0] paddr;
    logic [rfor_pkg::APB_DW-1:0] pwdata;
    logic [rfor_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    rfor_cmd_if cmd_bus ();
    rfor_rsp_if rsp_bus ();

    rect_fill_outline_raster_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the canvas and its registers
    logic [rfor_pkg::CHAR_W-1:0] shadow_canvas [CANVAS_MAX_W*CANVAS_MAX_H];
    bit                          painted       [CANVAS_MAX_W*CANVAS_MAX_H];
    logic [rfor_pkg::DIM_W-1:0]  cfg_width  = rfor_pkg::RST_CANVAS_WIDTH;
    logic [rfor_pkg::DIM_W-1:0]  cfg_height = rfor_pkg::RST_CANVAS_HEIGHT;
    logic [rfor_pkg::CHAR_W-1:0] cfg_bg     = rfor_pkg::RST_BACKGROUND;

    t_reply      pending_replies [$];
    int          err_count = 0;
    bit          idle_en;
    int unsigned cycle_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("rect_fill_outline_raster_top verification failed");
        $finish;
    end

    function automatic int cols_live();
        return (cfg_width > CANVAS_MAX_W) ? CANVAS_MAX_W : int'(cfg_width);
    endfunction

    function automatic int rows_live();
        return (cfg_height > CANVAS_MAX_H) ? CANVAS_MAX_H : int'(cfg_height);
    endfunction

    function automatic logic signed [rfor_pkg::COORD_W-1:0] fx(int whole, int frac);
        return rfor_pkg::COORD_W'(whole * ONE + frac);
    endfunction

    // Applies one command to the shadow canvas and returns its response
    function automatic t_reply raster_apply(t_paint_cmd c);
        t_reply rp;
        int     wc, hc, idx;
        longint l, t, rt, bt, xf, yf;
        bit     rin, redge, paint;
        wc = cols_live();
        hc = rows_live();
        rp.status = rfor_pkg::ST_DONE;
        rp.pix    = '0;
        case (c.op)
            rfor_pkg::OP_CLEAR: begin
                for (int r = 0; r < hc; r++)
                    for (int k = 0; k < wc; k++) begin
                        idx = r * CANVAS_MAX_W + k;
                        shadow_canvas[idx] = cfg_bg;
                        painted[idx]       = 1'b1;
                    end
            end
            rfor_pkg::OP_READ: begin
                if (int'(c.col) >= wc || int'(c.row) >= hc)
                    rp.status = rfor_pkg::ST_REJECTED;
                else
                    rp.pix = shadow_canvas[int'(c.row) * CANVAS_MAX_W + int'(c.col)];
            end
            default: begin
                l  = longint'(c.left);
                t  = longint'(c.top);
                rt = l + longint'(c.w);
                bt = t + longint'(c.h);
                if (c.w <= 0 || c.h <= 0) begin
                    rp.status = rfor_pkg::ST_REJECTED;
                end else begin
                    for (int r = 0; r < hc; r++) begin
                        yf    = longint'(r) * ONE;
                        rin   = (t <= yf) && (yf <= bt);
                        redge = (yf < t + ONE) || (yf > bt - ONE);
                        if (rin)
                            for (int k = 0; k < wc; k++) begin
                                xf = longint'(k) * ONE;
                                if (l <= xf && xf <= rt) begin
                                    paint = (c.op == rfor_pkg::OP_FILL) || redge ||
                                            (xf < l + ONE) || (xf > rt - ONE);
                                    if (paint) begin
                                        idx = r * CANVAS_MAX_W + k;
                                        shadow_canvas[idx] = c.ch;
                                        painted[idx]       = 1'b1;
                                    end
                                end
                            end
                    end
                end
            end
        endcase
        return rp;
    endfunction

    // Command builders; fields an opcode ignores carry random values
    function automatic t_paint_cmd noise_cmd();
        t_paint_cmd c;
        c.op   = rfor_pkg::t_opcode'($urandom_range(0, 3));
        c.left = rfor_pkg::COORD_W'($urandom);
        c.top  = rfor_pkg::COORD_W'($urandom);
        c.w    = rfor_pkg::COORD_W'($urandom);
        c.h    = rfor_pkg::COORD_W'($urandom);
        c.ch   = rfor_pkg::CHAR_W'($urandom);
        c.col  = rfor_pkg::PIX_W'($urandom);
        c.row  = rfor_pkg::PIX_W'($urandom);
        return c;
    endfunction

    function automatic t_paint_cmd clr();
        t_paint_cmd c = noise_cmd();
        c.op = rfor_pkg::OP_CLEAR;
        return c;
    endfunction

    function automatic t_paint_cmd rd(int col, int row);
        t_paint_cmd c = noise_cmd();
        c.op  = rfor_pkg::OP_READ;
        c.col = rfor_pkg::PIX_W'(col);
        c.row = rfor_pkg::PIX_W'(row);
        return c;
    endfunction

    function automatic t_paint_cmd rect(rfor_pkg::t_opcode op,
                                        logic signed [rfor_pkg::COORD_W-1:0] l, t, w, h,
                                        logic [rfor_pkg::CHAR_W-1:0] ch);
        t_paint_cmd c = noise_cmd();
        c.op   = op;
        c.left = l;
        c.top  = t;
        c.w    = w;
        c.h    = h;
        c.ch   = ch;
        return c;
    endfunction

    // Mostly well-formed commands around the live canvas, some raw noise
    function automatic t_paint_cmd random_cmd();
        t_paint_cmd c;
        int         wc, hc, pick;
        c    = noise_cmd();
        wc   = cols_live();
        hc   = rows_live();
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            c.op = rfor_pkg::OP_CLEAR;
        end else if (pick < 50) begin
            c.op = rfor_pkg::OP_READ;
            if ($urandom_range(0, 4) != 0 && wc > 0 && hc > 0) begin
                c.col = rfor_pkg::PIX_W'($urandom_range(0, wc - 1));
                c.row = rfor_pkg::PIX_W'($urandom_range(0, hc - 1));
            end
        end else begin
            c.op = (pick < 75) ? rfor_pkg::OP_FILL : rfor_pkg::OP_OUTLINE;
            if ($urandom_range(0, 9) != 0) begin
                c.left = rfor_pkg::COORD_W'(int'($urandom_range(0, (wc + 8) * ONE)) - 4 * ONE);
                c.top  = rfor_pkg::COORD_W'(int'($urandom_range(0, (hc + 8) * ONE)) - 4 * ONE);
                c.w    = rfor_pkg::COORD_W'($urandom_range(1, (wc + 2) * ONE));
                c.h    = rfor_pkg::COORD_W'($urandom_range(1, (hc + 2) * ONE));
                if ($urandom_range(0, 9) == 0)
                    c.w = rfor_pkg::COORD_W'(-int'($urandom_range(0, 3 * ONE)));
                if ($urandom_range(0, 9) == 0)
                    c.h = rfor_pkg::COORD_W'(-int'($urandom_range(0, 3 * ONE)));
            end
        end
        return c;
    endfunction

    // Sends one command beat, predicts its response once accepted
    task automatic send_cmd(t_paint_cmd c);
        int wc, hc;
        wc = cols_live();
        hc = rows_live();
        // never read a pixel that nothing has written yet
        if (c.op == rfor_pkg::OP_READ && int'(c.col) < wc && int'(c.row) < hc &&
            !painted[int'(c.row) * CANVAS_MAX_W + int'(c.col)]) begin
            if (wc < CANVAS_MAX_W)
                c.col = rfor_pkg::PIX_W'(wc);
            else if (hc < CANVAS_MAX_H)
                c.row = rfor_pkg::PIX_W'(hc);
            else
                c.op = rfor_pkg::OP_CLEAR;
        end
        if (idle_en && $urandom_range(0, 2) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.opcode    <= c.op;
        cmd_bus.rect_left <= c.left;
        cmd_bus.rect_top  <= c.top;
        cmd_bus.rect_w    <= c.w;
        cmd_bus.rect_h    <= c.h;
        cmd_bus.fill_char <= c.ch;
        cmd_bus.pixel_col <= c.col;
        cmd_bus.pixel_row <= c.row;
        do @(posedge i_clk); while (!cmd_bus.ready);
        pending_replies.push_back(raster_apply(c));
    endtask

    // Drops valid and waits until every response is back
    task automatic wait_replies();
        cmd_bus.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic reg_write(rfor_pkg::t_reg_idx idx, int value);
        logic [rfor_pkg::APB_DW-1:0] want;
        want = (idx == rfor_pkg::REG_BACKGROUND) ? rfor_pkg::APB_DW'(value & 8'hFF)
                                                 : rfor_pkg::APB_DW'(value & 10'h3FF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= rfor_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("prdata reg %0d: expected %0h, got %0h", idx, want, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            rfor_pkg::REG_CANVAS_WIDTH:  cfg_width  = rfor_pkg::DIM_W'(value);
            rfor_pkg::REG_CANVAS_HEIGHT: cfg_height = rfor_pkg::DIM_W'(value);
            rfor_pkg::REG_BACKGROUND:    cfg_bg     = rfor_pkg::CHAR_W'(value);
            default: ;
        endcase
        // bus left idle before the next transfer
        @(posedge i_clk);
    endtask

    task automatic set_canvas(int w, int h, int bg);
        wait_replies();
        reg_write(rfor_pkg::REG_CANVAS_WIDTH, w);
        reg_write(rfor_pkg::REG_CANVAS_HEIGHT, h);
        reg_write(rfor_pkg::REG_BACKGROUND, bg);
    endtask

    // Response checker and receiver stall pattern
    initial begin : reply_checker
        t_reply want;
        int     stall_left;
        stall_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
                if (pending_replies.size() == 0) begin
                    $error("response beat with no command outstanding");
                    err_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (rsp_bus.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                        err_count++;
                    end
                    if (rsp_bus.pixel_char !== want.pix) begin
                        $error("pixel_char: expected %0h, got %0h",
                               want.pix, rsp_bus.pixel_char);
                        err_count++;
                    end
                end
            end
            if (!idle_en) begin
                rsp_bus.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Reset registers: 1x1 canvas, space background
    task automatic test_reset_defaults();
        send_cmd(clr());
        send_cmd(rd(0, 0));
        send_cmd(rd(1, 0));
        send_cmd(rd(0, 1));
    endtask

    // Hand-placed rectangles, rejections and coordinate extremes
    task automatic test_directed_paint();
        set_canvas(16, 12, CH_UPPER_R);
        send_cmd(clr());
        send_cmd(rd(0, 0));
        send_cmd(rd(15, 11));
        send_cmd(rd(16, 0));
        send_cmd(rd(0, 12));
        send_cmd(rd(511, 511));
        send_cmd(rect(rfor_pkg::OP_FILL, fx(2, 0), fx(1, 0), fx(3, 0), fx(2, 0), CH_LOWER_R));
        send_cmd(rd(2, 1));
        send_cmd(rd(5, 3));
        send_cmd(rd(6, 3));
        // fractional outline: interior must stay background
        send_cmd(rect(rfor_pkg::OP_OUTLINE, fx(4, 128), fx(2, 64), fx(6, 0), fx(5, 128),
                      CH_HASH));
        send_cmd(rd(7, 5));
        send_cmd(rd(10, 7));
        // nonpositive sizes are rejected
        send_cmd(rect(rfor_pkg::OP_FILL, fx(1, 0), fx(1, 0), fx(0, 0), fx(2, 0), CH_HASH));
        send_cmd(rect(rfor_pkg::OP_FILL, fx(1, 0), fx(1, 0), fx(2, 0), Q_MIN, CH_HASH));
        send_cmd(rect(rfor_pkg::OP_OUTLINE, fx(1, 0), fx(1, 0), Q_MIN, Q_MIN, CH_HASH));
        // far off canvas, then covering it from the origin
        send_cmd(rect(rfor_pkg::OP_FILL, Q_MIN, Q_MIN, Q_MAX, Q_MAX, CH_HASH));
        send_cmd(rect(rfor_pkg::OP_FILL, Q_MAX, Q_MAX, Q_MAX, Q_MAX, CH_HASH));
        send_cmd(rect(rfor_pkg::OP_OUTLINE, fx(0, 0), fx(0, 0), Q_MAX, Q_MAX, 8'hFF));
        send_cmd(rd(0, 5));
        send_cmd(rd(3, 3));
        // sliver narrower than one unit: every covered pixel is edge
        send_cmd(rect(rfor_pkg::OP_OUTLINE, fx(1, 0), fx(8, 0), rfor_pkg::COORD_W'(1),
                      fx(3, 0), 8'h00));
        send_cmd(rd(1, 10));
    endtask

    // Oversized, zero and odd register values; contents kept across resize
    task automatic test_register_extremes();
        set_canvas(1023, 2, 0);
        send_cmd(clr());
        send_cmd(rd(511, 1));
        send_cmd(rd(511, 2));
        send_cmd(rect(rfor_pkg::OP_FILL, fx(500, 0), fx(0, 0), fx(20, 0), fx(1, 0),
                      CH_LOWER_R));
        send_cmd(rd(511, 0));
        send_cmd(rd(499, 0));
        set_canvas(3, 1023, 255);
        send_cmd(clr());
        send_cmd(rd(2, 511));
        send_cmd(rd(3, 0));
        send_cmd(rect(rfor_pkg::OP_OUTLINE, fx(0, 0), fx(300, 0), fx(2, 0), fx(211, 0),
                      CH_HASH));
        send_cmd(rd(1, 400));
        send_cmd(rd(1, 300));
        set_canvas(0, 5, CH_DOT);
        send_cmd(clr());
        send_cmd(rd(0, 0));
        send_cmd(rect(rfor_pkg::OP_FILL, fx(0, 0), fx(0, 0), fx(2, 0), fx(2, 0), CH_HASH));
        set_canvas(5, 0, CH_DOT);
        send_cmd(clr());
        send_cmd(rect(rfor_pkg::OP_OUTLINE, fx(0, 0), fx(0, 0), fx(2, 0), fx(2, 0), CH_HASH));
        send_cmd(rd(0, 0));
        // shrink, then grow back without a clear
        set_canvas(8, 4, CH_UPPER_R);
        send_cmd(clr());
        send_cmd(rect(rfor_pkg::OP_FILL, fx(0, 0), fx(0, 0), fx(7, 0), fx(3, 0), CH_LOWER_R));
        wait_replies();
        reg_write(rfor_pkg::REG_CANVAS_WIDTH, 4);
        send_cmd(rd(5, 0));
        wait_replies();
        reg_write(rfor_pkg::REG_CANVAS_WIDTH, 8);
        send_cmd(rd(5, 0));
        send_cmd(rd(7, 3));
        set_canvas(300, 1, CH_UPPER_R);
        send_cmd(clr());
        send_cmd(rect(rfor_pkg::OP_OUTLINE, fx(-2, 17), fx(-1, 0), fx(290, 3), fx(4, 0),
                      CH_HASH));
        send_cmd(rd(299, 0));
        send_cmd(rd(150, 0));
    endtask

    // One pass over the largest canvas
    task automatic test_full_canvas();
        set_canvas(CANVAS_MAX_W, CANVAS_MAX_H, CH_DOT);
        send_cmd(clr());
        send_cmd(rect(rfor_pkg::OP_OUTLINE, fx(0, 0), fx(0, 0), fx(511, 0), fx(511, 0),
                      CH_STAR));
        send_cmd(rd(0, 0));
        send_cmd(rd(511, 511));
        send_cmd(rd(256, 256));
        send_cmd(rd(511, 300));
        send_cmd(rd(300, 0));
        send_cmd(rd($urandom_range(0, 511), $urandom_range(0, 511)));
    endtask

    // Random canvases, each cleared first; the last phases run without idling
    task automatic test_random_phases();
        int wdim, hdim, pick;
        for (int ph = 0; ph < 6; ph++) begin
            wait_replies();
            idle_en <= (ph < 4) && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                wdim = 0;
            else if (pick == 1)
                wdim = $urandom_range(513, 1023);
            else
                wdim = $urandom_range(1, 24);
            pick = $urandom_range(0, 9);
            if (wdim > 24)
                hdim = $urandom_range(1, 2);
            else if (pick == 0)
                hdim = 0;
            else if (pick == 1) begin
                hdim = $urandom_range(600, 1023);
                if (wdim > 2)
                    wdim = 2;
            end else
                hdim = $urandom_range(1, 16);
            set_canvas(wdim, hdim, $urandom_range(0, 255));
            send_cmd(clr());
            repeat (7) send_cmd(random_cmd());
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.opcode    <= '0;
        cmd_bus.rect_left <= '0;
        cmd_bus.rect_top  <= '0;
        cmd_bus.rect_w    <= '0;
        cmd_bus.rect_h    <= '0;
        cmd_bus.fill_char <= '0;
        cmd_bus.pixel_col <= '0;
        cmd_bus.pixel_row <= '0;
        idle_en           <= 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_paint();
        test_register_extremes();
        test_full_canvas();
        test_random_phases();
        wait_replies();

        if (err_count == 0)
            $display("rect_fill_outline_raster_top verification clean");
        else
            $display("rect_fill_outline_raster_top verification failed");
        $finish;
    end

endmodule
